/* design/vosc_pkg.sv */
`default_nettype none

package vosc_pkg;

    // Capacity of the adjacency store and the walk stack
    localparam int MAX_V   = 64;
    localparam int IDX_W   = $clog2(MAX_V);
    localparam int CNT_W   = $clog2(MAX_V + 1);
    localparam int FIELD_W = 7;
    localparam int CFG_AW  = 1;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] REG_START_VERTEX = 1'b1;

    typedef logic [MAX_V-1:0] t_row;
    typedef logic [IDX_W-1:0] t_idx;

    // One edge transfer
    typedef struct packed {
        logic [FIELD_W-1:0] end_a;
        logic [FIELD_W-1:0] end_b;
        logic               edge_valid;
        logic               last_edge;
    } t_in;

    // One result transfer
    typedef struct packed {
        logic [FIELD_W-1:0] vertex;
        logic               last;
    } t_out;

    // Access request to the adjacency store
    typedef struct packed {
        logic rd_en;
        t_idx rd_addr;
        logic wr_en;
        t_idx wr_addr;
        t_row wr_data;
        logic clr;
    } t_adj_req;

    // Index of the lowest set bit (zero when none is set)
    function automatic t_idx low_index(input t_row x);
        t_row one;
        t_idx r;
        one = x & (~x + t_row'(1));
        r   = '0;
        for (int i = 0; i < MAX_V; i++) begin
            if (one[i]) begin
                r = r | t_idx'(i);
            end
        end
        return r;
    endfunction

    // Bits of the vertices in use: index i is set when i < n
    function automatic t_row vertex_mask(input logic [CNT_W-1:0] n);
        t_row m;
        for (int i = 0; i < MAX_V; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* design/vertices_outside_start_component.sv */
`default_nettype none

// Finds the vertices outside the connected component of a start vertex.
// Input channel (i_in_valid / o_in_stall, payload i_in): one transfer per
// edge. An edge with both endpoints in 1..vertex_count (at most 64) is set
// in both rows of the adjacency store; other edges are dropped. An edge
// transfer runs a read-modify-write of its two rows in the store, while an
// empty item is taken in the idle state.
// The transfer with last_edge set starts a depth-first walk from
// start_vertex: a seed step, then per reached vertex a stack pop, row
// read and scan, plus a push step per newly reached neighbour.
// Output channel (o_out_valid / i_out_stall, payload o_out): the vertices
// the walk missed, ascending, one per transfer and cycle, last set on the
// final one; vertex 0 with last when all were reached. A stall holds the
// output register and the emit simply waits.
// When the final result is loaded the store, visited set and stack are
// cleared with it, and the next edge is taken while that result waits.
// Configuration (i_cfg_we / i_cfg_addr / i_cfg_data): vertex_count,
// start_vertex; write only while idle.
// Reset (synchronous, active low): empty store, vertex_count 64, start 1.
module vertices_outside_start_component import vosc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in                i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out                    o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [FIELD_W-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_UPD_A = 9'b000000010,
        S_UPD_B = 9'b000000100,
        S_START = 9'b000001000,
        S_POP   = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_PUSH  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_vertex_count;
    logic [FIELD_W-1:0] r_start_vertex;
    t_idx               r_a, n_a;
    t_idx               r_b, n_b;
    logic               r_last, n_last;
    logic [CNT_W-1:0]   r_depth, n_depth;
    t_row               r_visited, n_visited;
    t_row               r_pend, n_pend;
    t_row               r_rem, n_rem;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    // Walk stack memory
    t_idx r_stack [MAX_V];
    t_idx r_stack_rd;
    logic stk_we, stk_re;
    t_idx stk_waddr, stk_wdata, stk_raddr;

    t_adj_req         adj_req;
    t_row             adj_row;
    logic [CNT_W-1:0] used;
    t_row             vmask;
    logic             edge_ok;
    logic             start_ok;
    t_row             scan_new;
    t_row             pend_rest;
    t_row             rem_rest;

    vosc_adj_mem u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (adj_req),
        .o_row   (adj_row)
    );

    // Count in use, clamped to the store size
    assign used  = (int'(r_vertex_count) > MAX_V) ? CNT_W'(MAX_V)
                                                  : CNT_W'(r_vertex_count);
    assign vmask = vertex_mask(used);

    assign edge_ok = i_in.edge_valid
                  && (i_in.end_a != '0) && (int'(i_in.end_a) <= int'(used))
                  && (i_in.end_b != '0) && (int'(i_in.end_b) <= int'(used));
    assign start_ok = (r_start_vertex != '0) && (int'(r_start_vertex) <= int'(used));

    assign scan_new  = adj_row & ~r_visited & vmask;
    assign pend_rest = r_pend & (r_pend - t_row'(1));
    assign rem_rest  = r_rem & (r_rem - t_row'(1));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer: edge update, walk, emit
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_last      = r_last;
        n_depth     = r_depth;
        n_visited   = r_visited;
        n_pend      = r_pend;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        adj_req     = '0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a    = t_idx'(i_in.end_a - FIELD_W'(1));
                    n_b    = t_idx'(i_in.end_b - FIELD_W'(1));
                    n_last = i_in.last_edge;
                    if (edge_ok) begin
                        adj_req.rd_en   = 1'b1;
                        adj_req.rd_addr = t_idx'(i_in.end_a - FIELD_W'(1));
                        n_state         = S_UPD_A;
                    end else if (i_in.last_edge) begin
                        n_state = S_START;
                    end
                end
            end
            S_UPD_A: begin
                // a self loop reads the old row here and sets the same bit again
                adj_req.wr_en   = 1'b1;
                adj_req.wr_addr = r_a;
                adj_req.wr_data = adj_row | (t_row'(1) << r_b);
                adj_req.rd_en   = 1'b1;
                adj_req.rd_addr = r_b;
                n_state         = S_UPD_B;
            end
            S_UPD_B: begin
                adj_req.wr_en   = 1'b1;
                adj_req.wr_addr = r_b;
                adj_req.wr_data = adj_row | (t_row'(1) << r_a);
                n_state         = r_last ? S_START : S_IDLE;
            end
            S_START: begin
                if (start_ok) begin
                    n_visited = t_row'(1) << t_idx'(r_start_vertex - FIELD_W'(1));
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = t_idx'(r_start_vertex - FIELD_W'(1));
                    n_depth   = CNT_W'(1);
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_depth == '0) begin
                    n_rem   = ~r_visited & vmask;
                    n_state = S_EMIT;
                end else begin
                    n_depth   = r_depth - CNT_W'(1);
                    stk_re    = 1'b1;
                    stk_raddr = t_idx'(r_depth - CNT_W'(1));
                    n_state   = S_LOAD;
                end
            end
            S_LOAD: begin
                adj_req.rd_en   = 1'b1;
                adj_req.rd_addr = r_stack_rd;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                n_pend    = scan_new;
                n_visited = r_visited | scan_new;
                n_state   = (scan_new != '0) ? S_PUSH : S_POP;
            end
            S_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = t_idx'(r_depth);
                stk_wdata = low_index(r_pend);
                n_depth   = r_depth + CNT_W'(1);
                n_pend    = pend_rest;
                if (pend_rest == '0) begin
                    n_state = S_POP;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_rem == '0) begin
                        n_out.vertex = '0;
                        n_out.last   = 1'b1;
                    end else begin
                        n_out.vertex = FIELD_W'(low_index(r_rem)) + FIELD_W'(1);
                        n_out.last   = (rem_rest == '0);
                    end
                    n_rem = rem_rest;
                    if (n_out.last) begin
                        adj_req.clr = 1'b1;
                        n_visited   = '0;
                        n_depth     = '0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_visited   <= '0;
            r_pend      <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_visited   <= n_visited;
            r_pend      <= n_pend;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_last <= n_last;
        r_out  <= n_out;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= FIELD_W'(64);
            r_start_vertex <= FIELD_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                REG_START_VERTEX: r_start_vertex <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Walk stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stack_rd <= r_stack[stk_raddr];
        end
    end

    // Each vertex is pushed at most once
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= MAX_V)
        else $error("walk stack overflow");

    // Push loop only runs with neighbors pending
    a_push_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_pend != '0))
        else $error("push with nothing pending");

    // The all-reached marker is always the final result
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.vertex == '0)) |-> o_out.last)
        else $error("vertex zero without last");

    // An empty non-final item leaves the block idle
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in.edge_valid && !i_in.last_edge)
        |=> (r_state == S_IDLE))
        else $error("empty item started work");

endmodule

`default_nettype wire

/* design/vosc_adj_mem.sv */
`default_nettype none

module vosc_adj_mem import vosc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_adj_req i_req,
    output t_row          o_row
);

    // Row storage, one row per vertex
    t_row r_mem [MAX_V];
    t_row r_rd;

    // Per-row valid bits: a row not written since the last clear reads as zero
    t_row r_row_vld;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_row_vld <= '0;
            end else if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_row = r_rd_vld ? r_rd : '0;

    // Clear empties every row at once
    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clr |=> (r_row_vld == '0))
        else $error("adjacency rows still valid after clear");

    // A written row is valid afterwards unless cleared
    a_wr_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.wr_en && !i_req.clr) |=> r_row_vld[$past(i_req.wr_addr)])
        else $error("written adjacency row not marked valid");

    // A clear never coincides with a row update
    a_clr_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clr |-> !i_req.wr_en)
        else $error("adjacency clear during write");

endmodule

`default_nettype wire

/* bench/vertices_outside_start_component_test.sv */
`timescale 1ns / 1ps

module vertices_outside_start_component_test import vosc_pkg::*;;

    // Clock, reset and block ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in                i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out               o_out;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr  = '0;
    logic [FIELD_W-1:0] i_cfg_data  = '0;

    // Pending edge items and expected unreached vertices
    t_in  link_q [$];
    t_out unreached_q [$];
    int   items_queued  = 0;
    int   items_taken   = 0;
    int   mismatches    = 0;
    logic in_took       = 1'b0;

    // Idle percentages of the current phase
    int   send_gap_pct  = 0;
    int   out_stall_pct = 0;

    // Predictor state: graph, reached set and register copies
    t_row               graph_rows [MAX_V];
    t_row               reached;
    logic [FIELD_W-1:0] vcount_reg = FIELD_W'(64);
    logic [FIELD_W-1:0] start_reg  = FIELD_W'(1);

    vertices_outside_start_component dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Store one edge; on the last item walk from the start vertex and
    // queue every vertex the walk missed, then clear the graph.
    task automatic take_link_item(input t_in item);
        int   n;
        int   a;
        int   b;
        int   s;
        int   u;
        int   depth;
        int   total;
        int   k;
        int   pending [MAX_V];
        t_out r;
        n = (int'(vcount_reg) > MAX_V) ? MAX_V : int'(vcount_reg);
        a = int'(item.end_a);
        b = int'(item.end_b);
        if (item.edge_valid && a >= 1 && b >= 1 && a <= n && b <= n) begin
            graph_rows[a-1][b-1] = 1'b1;
            graph_rows[b-1][a-1] = 1'b1;
        end
        if (!item.last_edge) return;

        // depth-first walk with an explicit stack
        s = int'(start_reg);
        depth = 0;
        if (s >= 1 && s <= n) begin
            reached[s-1] = 1'b1;
            pending[0] = s - 1;
            depth = 1;
        end
        while (depth > 0) begin
            depth--;
            u = pending[depth];
            for (int w = 0; w < n; w++) begin
                if (graph_rows[u][w] && !reached[w]) begin
                    reached[w] = 1'b1;
                    pending[depth] = w;
                    depth++;
                end
            end
        end

        // ascending list of missed vertices, or vertex 0 when none
        total = 0;
        for (int v = 0; v < n; v++) begin
            if (!reached[v]) total++;
        end
        if (total == 0) begin
            r.vertex = '0;
            r.last   = 1'b1;
            unreached_q = {unreached_q, r};
        end else begin
            k = 0;
            for (int v = 0; v < n; v++) begin
                if (!reached[v]) begin
                    k++;
                    r.vertex = FIELD_W'(v + 1);
                    r.last   = (k == total);
                    unreached_q = {unreached_q, r};
                end
            end
        end
        for (int i = 0; i < MAX_V; i++) graph_rows[i] = '0;
        reached = '0;
    endtask

    // Input driver and output stall, changed on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_took) begin
                if (link_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in       <= link_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Monitor: input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                take_link_item(i_in);
            end
            if (o_out_valid && !i_out_stall) begin
                if (unreached_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result vertex %0d last %0b",
                                              o_out.vertex, o_out.last));
                end else begin
                    want = unreached_q.pop_front();
                    if (o_out.vertex !== want.vertex)
                        report_mismatch($sformatf("vertex %0d, expected %0d",
                                                  o_out.vertex, want.vertex));
                    if (o_out.last !== want.last)
                        report_mismatch($sformatf("last %0b on vertex %0d, expected %0b",
                                                  o_out.last, want.vertex, want.last));
                end
            end
        end
    end

    task automatic queue_item(input int a, input int b, input bit ev, input bit le);
        t_in item;
        item.end_a      = FIELD_W'(a);
        item.end_b      = FIELD_W'(b);
        item.edge_valid = ev;
        item.last_edge  = le;
        link_q = {link_q, item};
        items_queued++;
    endtask

    // Hold off until every queued item is taken and every result is out,
    // then let the block finish any edge update or clear in flight.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (items_taken != items_queued || unreached_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= FIELD_W'(val);
        if (idx == REG_VERTEX_COUNT) vcount_reg = FIELD_W'(val);
        else start_reg = FIELD_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_graph_config(input int count, input int start);
        write_reg(REG_VERTEX_COUNT, count);
        write_reg(REG_START_VERTEX, start);
        @(posedge i_clk);
    endtask

    // One random graph: mostly edges inside the vertex range, some outside,
    // a few empty items; the final item carries the last mark.
    task automatic queue_random_graph();
        int n;
        int links;
        int a;
        int b;
        n = (int'(vcount_reg) > MAX_V) ? MAX_V : int'(vcount_reg);
        links = $urandom_range(1, (n > 16) ? 24 : n + 4);
        for (int i = 0; i < links; i++) begin
            if (n > 0 && $urandom_range(99) < 88) begin
                a = $urandom_range(1, n);
                b = $urandom_range(1, n);
            end else begin
                a = $urandom_range(0, 127);
                b = $urandom_range(0, 127);
            end
            queue_item(a, b, $urandom_range(9) != 0, i == links - 1);
        end
    endtask

    // Stimulus
    initial begin
        int seg;
        int count;
        int start;
        int pick;
        for (int i = 0; i < MAX_V; i++) graph_rows[i] = '0;
        reached = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: self loop, zero and oversize endpoints,
        // an empty item, and an edge carried on the last item
        queue_item(1, 64, 1, 0);
        queue_item(64, 64, 1, 0);
        queue_item(0, 5, 1, 0);
        queue_item(127, 3, 1, 0);
        queue_item(127, 127, 0, 0);
        queue_item(2, 3, 1, 0);
        queue_item(1, 2, 1, 1);
        wait_quiet();

        // every vertex reached
        set_graph_config(3, 1);
        queue_item(1, 2, 1, 0);
        queue_item(3, 2, 1, 1);
        wait_quiet();

        // no vertices at all
        set_graph_config(0, 1);
        queue_item(1, 1, 1, 1);
        wait_quiet();

        // single vertex, empty last item
        set_graph_config(1, 1);
        queue_item(0, 0, 0, 1);
        wait_quiet();

        // count above capacity, start at the top vertex
        set_graph_config(127, 64);
        queue_item(64, 63, 1, 0);
        queue_item(65, 1, 1, 0);
        queue_item(63, 62, 1, 1);
        wait_quiet();

        // start vertex zero, then above the count
        set_graph_config(5, 0);
        queue_item(1, 2, 1, 1);
        wait_quiet();
        set_graph_config(5, 9);
        queue_item(2, 3, 1, 1);
        wait_quiet();

        // count lowered after edges are loaded: vertex 10 is not followed
        set_graph_config(10, 1);
        queue_item(1, 10, 1, 0);
        queue_item(10, 2, 1, 0);
        queue_item(1, 3, 1, 0);
        wait_quiet();
        write_reg(REG_VERTEX_COUNT, 5);
        @(posedge i_clk);
        queue_item(4, 4, 1, 1);
        wait_quiet();

        // random graphs, idle mode and registers changed per segment
        seg = 0;
        while (items_queued < 330) begin
            case (seg % 4)
                0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin send_gap_pct = 72; out_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  out_stall_pct = 72; end
                default: begin send_gap_pct = 14; out_stall_pct = 14; end
            endcase
            pick = $urandom_range(19);
            if (pick == 0) count = 0;
            else if (pick == 1) count = $urandom_range(65, 127);
            else if (pick <= 4) count = 64;
            else count = $urandom_range(1, 16);
            if ($urandom_range(9) == 0)
                start = $urandom_range(0, 127);
            else
                start = $urandom_range(1, (count == 0) ? 1 : ((count > 64) ? 64 : count));
            set_graph_config(count, start);
            repeat ($urandom_range(2, 4)) queue_random_graph();
            wait_quiet();
            seg++;
        end

        // tail: the last results are in; allow for stray ones
        send_gap_pct  = 0;
        out_stall_pct = 0;
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && unreached_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Timeout
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
design/vosc_pkg.sv
design/vosc_adj_mem.sv
design/vertices_outside_start_component.sv
bench/vertices_outside_start_component_test.sv
